// ===== rtl/core/mgmt_frame_contact_tracker_core_defines.svh =====
// assertion macros for the management frame contact tracker
`ifndef MGMT_FRAME_CONTACT_TRACKER_CORE_DEFINES_SVH
`define MGMT_FRAME_CONTACT_TRACKER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MFTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MFTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mftc_pkg.sv =====
// types and constants for the management frame contact tracker
`default_nettype none

package mftc_pkg;

  localparam int DRONE_SLOTS_DEF     = 4;
  localparam int FRAME_BYTES_MAX_DEF = 4095;

  // frame layout
  localparam int FCS_LEN        = 4;
  localparam int MIN_HDR_LEN    = 24;
  localparam int MIN_ACTION_LEN = 32;
  localparam int SSID_HDR_END   = 38;
  localparam int NAME_LEN_LIMIT = 32;
  localparam int IDX_TYPE       = 0;
  localparam int IDX_SRC_FIRST  = 10;
  localparam int IDX_SRC_LAST   = 15;
  localparam int IDX_CATEGORY   = 24;
  localparam int IDX_ACTION     = 25;
  localparam int IDX_OUI0       = 27;
  localparam int IDX_OUI1       = 28;
  localparam int IDX_OUI2       = 29;
  localparam int IDX_SSID_ID    = 36;
  localparam int IDX_SSID_LEN   = 37;

  localparam logic [7:0]  TYPE_BEACON  = 8'h80;
  localparam logic [7:0]  TYPE_ACTION  = 8'hD0;
  localparam logic [7:0]  CAT_PUBLIC   = 8'h04;
  localparam logic [7:0]  ACT_VENDOR   = 8'h09;
  localparam logic [7:0]  WFA_OUI0     = 8'h50;
  localparam logic [7:0]  WFA_OUI1     = 8'h6F;
  localparam logic [7:0]  WFA_OUI2     = 8'h9A;
  localparam logic [4:0]  ACT_ALL_HIT  = 5'h1F;
  localparam logic [47:0] HOSTILE_ADDR = 48'hDEAD_BEEF_DEAD;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_HOST_NEW    = 3'd1,
    EV_HOST_AGAIN  = 3'd2,
    EV_DRONE_NEW   = 3'd3,
    EV_DRONE_AGAIN = 3'd4,
    EV_DRONE_FULL  = 3'd5
  } ev_t;

  typedef struct packed {
    logic [7:0]         frame_byte;
    logic               last_byte;
    logic               mgmt_frame;
    logic signed [7:0]  rssi;
    logic [31:0]        time_ms;
  } in_word_t;

  typedef struct packed {
    ev_t                event_res;
    logic [1:0]         slot;
    logic [47:0]        source_addr;
    logic signed [7:0]  signal;
    logic [15:0]        seen_count;
    logic [4:0]         name_length;
    logic [2:0]         drone_count;
  } out_word_t;

  // drone table request and response
  typedef struct packed {
    logic               go;
    logic [47:0]        src;
    logic signed [7:0]  rssi;
    logic [31:0]        time_ms;
  } dt_req_t;

  typedef struct packed {
    ev_t                ev;
    logic [1:0]         slot;
    logic [2:0]         count;
  } dt_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/mgmt_frame_contact_tracker_core.sv =====
// Management frame contact tracker. Frame bytes come in one word per cycle while
// in_stall is low on the in_ channel, the final byte marked by last_byte;
// management flag, RSSI and time are sampled with that final byte. Each word
// passes an input register, then capture and decision logic into the result
// register, so a word is accepted every cycle while in_stall is low. Exactly one
// result is produced per frame; in_stall rises only while a final byte waits
// behind a result that out_stall holds back. The source address, type byte,
// public action body and SSID header are captured as bytes stream past; the
// four-slot drone table is searched by a parallel address compare in the same
// cycle as the decision.
`default_nettype none

`include "mgmt_frame_contact_tracker_core_defines.svh"

module mgmt_frame_contact_tracker_core #(
  parameter int DRONE_SLOTS     = mftc_pkg::DRONE_SLOTS_DEF,
  parameter int FRAME_BYTES_MAX = mftc_pkg::FRAME_BYTES_MAX_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire mftc_pkg::in_word_t in_word,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output mftc_pkg::out_word_t  out_word
);

  localparam int CNT_W = $clog2(FRAME_BYTES_MAX + 1);

  // input register
  logic                s1_valid_r, s1_valid_nxt;
  mftc_pkg::in_word_t  s1_r;
  logic                adv;
  logic                accept;

  // per-frame capture
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_cap;
  logic [7:0]       first_r, first_nxt, first_cap;
  logic [47:0]      sender_r, sender_nxt, sender_cap;
  logic [4:0]       flags_r, flags_nxt, flags_cap;
  logic [15:0]      ssid_r, ssid_nxt, ssid_cap;

  // hostile record
  logic              host_present_r, host_present_nxt;
  logic [15:0]       host_seen_r, host_seen_nxt;
  logic [4:0]        host_nlen_r, host_nlen_nxt;
  logic signed [7:0] host_signal_r, host_signal_nxt;
  logic [31:0]       host_first_r, host_first_nxt;
  logic [31:0]       host_last_r, host_last_nxt;

  // decision
  logic [CNT_W-1:0]    len;
  logic                done;
  logic                is_host;
  logic                is_drone;
  logic [4:0]          nlen_new;
  mftc_pkg::dt_req_t   dt_req;
  mftc_pkg::dt_rsp_t   dt_rsp;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  mftc_pkg::out_word_t  out_word_r, out_word_nxt;

  assign adv      = s1_valid_r && (!s1_r.last_byte || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign accept   = in_valid && !in_stall;
  assign done     = adv && s1_r.last_byte;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= in_word;
    end
  end

  // byte capture, including the word at hand
  always_comb begin
    cnt_cap    = cnt_r;
    first_cap  = first_r;
    sender_cap = sender_r;
    flags_cap  = flags_r;
    ssid_cap   = ssid_r;
    if (cnt_r < CNT_W'(FRAME_BYTES_MAX)) begin
      cnt_cap = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(mftc_pkg::IDX_TYPE)) begin
        first_cap = s1_r.frame_byte;
      end
      if (cnt_r >= CNT_W'(mftc_pkg::IDX_SRC_FIRST) &&
          cnt_r <= CNT_W'(mftc_pkg::IDX_SRC_LAST)) begin
        sender_cap = {sender_r[39:0], s1_r.frame_byte};
      end
      if (cnt_r == CNT_W'(mftc_pkg::IDX_CATEGORY) &&
          s1_r.frame_byte == mftc_pkg::CAT_PUBLIC) begin
        flags_cap[0] = 1'b1;
      end
      if (cnt_r == CNT_W'(mftc_pkg::IDX_ACTION) &&
          s1_r.frame_byte == mftc_pkg::ACT_VENDOR) begin
        flags_cap[1] = 1'b1;
      end
      if (cnt_r == CNT_W'(mftc_pkg::IDX_OUI0) && s1_r.frame_byte == mftc_pkg::WFA_OUI0) begin
        flags_cap[2] = 1'b1;
      end
      if (cnt_r == CNT_W'(mftc_pkg::IDX_OUI1) && s1_r.frame_byte == mftc_pkg::WFA_OUI1) begin
        flags_cap[3] = 1'b1;
      end
      if (cnt_r == CNT_W'(mftc_pkg::IDX_OUI2) && s1_r.frame_byte == mftc_pkg::WFA_OUI2) begin
        flags_cap[4] = 1'b1;
      end
      if (cnt_r == CNT_W'(mftc_pkg::IDX_SSID_ID)) begin
        ssid_cap[15:8] = s1_r.frame_byte;
      end
      if (cnt_r == CNT_W'(mftc_pkg::IDX_SSID_LEN)) begin
        ssid_cap[7:0] = s1_r.frame_byte;
      end
    end

    cnt_nxt    = cnt_r;
    first_nxt  = first_r;
    sender_nxt = sender_r;
    flags_nxt  = flags_r;
    ssid_nxt   = ssid_r;
    if (done) begin
      cnt_nxt    = '0;
      first_nxt  = '0;
      sender_nxt = '0;
      flags_nxt  = '0;
      ssid_nxt   = '0;
    end else if (adv) begin
      cnt_nxt    = cnt_cap;
      first_nxt  = first_cap;
      sender_nxt = sender_cap;
      flags_nxt  = flags_cap;
      ssid_nxt   = ssid_cap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      first_r  <= '0;
      sender_r <= '0;
      flags_r  <= '0;
      ssid_r   <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      first_r  <= first_nxt;
      sender_r <= sender_nxt;
      flags_r  <= flags_nxt;
      ssid_r   <= ssid_nxt;
    end
  end

  // frame classification on the final byte
  always_comb begin
    len = (cnt_cap > CNT_W'(mftc_pkg::FCS_LEN)) ? cnt_cap - CNT_W'(mftc_pkg::FCS_LEN)
                                                : cnt_cap;
    is_host  = s1_r.mgmt_frame && (len >= CNT_W'(mftc_pkg::MIN_HDR_LEN)) &&
               (first_cap == mftc_pkg::TYPE_BEACON) && (sender_cap == mftc_pkg::HOSTILE_ADDR);
    is_drone = s1_r.mgmt_frame && !is_host && (first_cap == mftc_pkg::TYPE_ACTION) &&
               (len >= CNT_W'(mftc_pkg::MIN_ACTION_LEN)) && (flags_cap == mftc_pkg::ACT_ALL_HIT);

    // name only when the ssid element fits inside the frame body
    nlen_new = '0;
    if (len > CNT_W'(mftc_pkg::SSID_HDR_END) && ssid_cap[15:8] == 8'd0 &&
        ssid_cap[7:0] != 8'd0 && ssid_cap[7:0] < 8'(mftc_pkg::NAME_LEN_LIMIT) &&
        (CNT_W'(mftc_pkg::SSID_HDR_END) + CNT_W'(ssid_cap[4:0])) < len) begin
      nlen_new = ssid_cap[4:0];
    end

    dt_req.go      = done && is_drone;
    dt_req.src     = sender_cap;
    dt_req.rssi    = s1_r.rssi;
    dt_req.time_ms = s1_r.time_ms;
  end

  mftc_drone_tbl #(
    .DRONE_SLOTS (DRONE_SLOTS)
  ) u_drone_tbl (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dt_req),
    .rsp   (dt_rsp)
  );

  always_comb begin
    host_present_nxt = host_present_r;
    host_seen_nxt    = host_seen_r;
    host_nlen_nxt    = host_nlen_r;
    host_signal_nxt  = host_signal_r;
    host_first_nxt   = host_first_r;
    host_last_nxt    = host_last_r;
    if (done && is_host) begin
      host_signal_nxt = s1_r.rssi;
      host_last_nxt   = s1_r.time_ms;
      if (host_present_r) begin
        if (host_seen_r != 16'hFFFF) begin
          host_seen_nxt = host_seen_r + 16'd1;
        end
      end else begin
        host_present_nxt = 1'b1;
        host_seen_nxt    = 16'd1;
        host_nlen_nxt    = nlen_new;
        host_first_nxt   = s1_r.time_ms;
      end
    end

    out_word_nxt             = '0;
    out_word_nxt.event_res   = mftc_pkg::EV_NONE;
    out_word_nxt.source_addr = sender_cap;
    out_word_nxt.drone_count = dt_rsp.count;
    if (is_host) begin
      out_word_nxt.event_res   = host_present_r ? mftc_pkg::EV_HOST_AGAIN
                                                : mftc_pkg::EV_HOST_NEW;
      out_word_nxt.signal      = s1_r.rssi;
      out_word_nxt.seen_count  = host_seen_nxt;
      out_word_nxt.name_length = host_nlen_nxt;
    end else if (is_drone) begin
      out_word_nxt.event_res = dt_rsp.ev;
      out_word_nxt.slot      = dt_rsp.slot;
      if (dt_rsp.ev != mftc_pkg::EV_DRONE_FULL) begin
        out_word_nxt.signal = s1_r.rssi;
      end
    end

    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      host_present_r <= 1'b0;
      host_seen_r    <= '0;
      host_nlen_r    <= '0;
      host_signal_r  <= '0;
      host_first_r   <= '0;
      host_last_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      host_present_r <= host_present_nxt;
      host_seen_r    <= host_seen_nxt;
      host_nlen_r    <= host_nlen_nxt;
      host_signal_r  <= host_signal_nxt;
      host_first_r   <= host_first_nxt;
      host_last_r    <= host_last_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `MFTC_ASSERT_NEXT(a_frame_clear, done, cnt_r == '0, "byte count not cleared after final byte")
  `MFTC_ASSERT_NOW(a_host_again_seen,
    out_valid && out_word.event_res == mftc_pkg::EV_HOST_AGAIN, out_word.seen_count >= 16'd2,
    "repeat hostile sighting with count below two")
  `MFTC_ASSERT_NOW(a_full_no_slot,
    out_valid && out_word.event_res == mftc_pkg::EV_DRONE_FULL,
    out_word.slot == 2'd0 && out_word.signal == 8'sd0, "table full result touches a slot")
  `MFTC_ASSERT_NOW(a_none_quiet, out_valid && out_word.event_res == mftc_pkg::EV_NONE,
    out_word.seen_count == 16'd0 && out_word.name_length == 5'd0 && out_word.slot == 2'd0,
    "empty result carries record fields")

endmodule

`default_nettype wire

// ===== rtl/core/mftc_drone_tbl.sv =====
// drone table: parallel address match, refresh on hit and insert while not full
`default_nettype none

module mftc_drone_tbl #(
  parameter int DRONE_SLOTS = mftc_pkg::DRONE_SLOTS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mftc_pkg::dt_req_t req,
  output mftc_pkg::dt_rsp_t     rsp
);

  localparam int SLOT_W = (DRONE_SLOTS > 1) ? $clog2(DRONE_SLOTS) : 1;
  localparam int USED_W = $clog2(DRONE_SLOTS + 1);

  logic [47:0]       addr_r   [DRONE_SLOTS];
  logic signed [7:0] signal_r [DRONE_SLOTS];
  logic [31:0]       time_r   [DRONE_SLOTS];
  logic [USED_W-1:0] used_r, used_nxt;

  logic                   full;
  logic                   hit;
  logic [SLOT_W-1:0]      hit_idx;
  logic [SLOT_W-1:0]      slot_sel;
  logic [DRONE_SLOTS-1:0] match;
  logic [31:0]            slot_ext;
  logic [31:0]            used_ext;

  always_comb begin
    full = (used_r == USED_W'(DRONE_SLOTS));
    for (int i = 0; i < DRONE_SLOTS; i++) begin
      match[i] = (USED_W'(i) < used_r) && (addr_r[i] == req.src);
    end
    // lowest matching slot wins
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = DRONE_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
    slot_sel = hit ? hit_idx : used_r[SLOT_W-1:0];

    used_nxt = used_r;
    if (req.go && !full && !hit) begin
      used_nxt = used_r + 1'b1;
    end

    slot_ext = {{(32 - SLOT_W){1'b0}}, slot_sel};
    used_ext = {{(32 - USED_W){1'b0}}, used_nxt};

    if (full) begin
      rsp.ev   = mftc_pkg::EV_DRONE_FULL;
      rsp.slot = '0;
    end else if (hit) begin
      rsp.ev   = mftc_pkg::EV_DRONE_AGAIN;
      rsp.slot = slot_ext[1:0];
    end else begin
      rsp.ev   = mftc_pkg::EV_DRONE_NEW;
      rsp.slot = slot_ext[1:0];
    end
    rsp.count = used_ext[2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  // entries past used_r are never compared, so they need no reset
  always_ff @(posedge clk) begin
    if (req.go && !full) begin
      addr_r[slot_sel]   <= req.src;
      signal_r[slot_sel] <= req.rssi;
      time_r[slot_sel]   <= req.time_ms;
    end
  end

endmodule

`default_nettype wire

// ===== dv/mftc_report_checker.sv =====
// checker for the contact tracker: predicts each report from the accepted words and compares
module mftc_report_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  mftc_pkg::in_word_t   in_word,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  mftc_pkg::out_word_t  out_word,
  output int unsigned          fail_count,
  output int unsigned          pending_count,
  output int unsigned          reports_checked,
  output int unsigned          hostile_reports,
  output int unsigned          drone_reports
);
  import mftc_pkg::*;

  localparam int SLOTS = DRONE_SLOTS_DEF;

  // per-frame capture
  int                cap_count;
  logic [7:0]        cap_type;
  logic [47:0]       cap_src;
  logic [4:0]        cap_flags;
  logic [15:0]       cap_ssid;

  // drone table and hostile record
  logic [47:0]       slot_addr [SLOTS];
  logic signed [7:0] slot_sig  [SLOTS];
  int unsigned       slots_used;
  bit                host_known;
  logic signed [7:0] host_sig;
  logic [15:0]       host_seen;
  logic [4:0]        host_name;

  out_word_t         expected_reports [$];
  out_word_t         fresh_rep;
  out_word_t         oldest;
  int unsigned       mismatch_total = 0;
  int unsigned       checked_total = 0;
  int unsigned       hostile_total = 0;
  int unsigned       drone_total = 0;

  function automatic void clear_capture();
    cap_count = 0;
    cap_type  = '0;
    cap_src   = '0;
    cap_flags = '0;
    cap_ssid  = '0;
  endfunction

  function automatic bit predict_contact(input in_word_t w, output out_word_t rep);
    int unsigned len;
    int unsigned used;
    int unsigned name_sz;
    bit          hit;
    rep = '0;
    if (cap_count < FRAME_BYTES_MAX_DEF) begin
      if (cap_count == IDX_TYPE) cap_type = w.frame_byte;
      if (cap_count >= IDX_SRC_FIRST && cap_count <= IDX_SRC_LAST)
        cap_src = {cap_src[39:0], w.frame_byte};
      if (cap_count == IDX_CATEGORY && w.frame_byte == CAT_PUBLIC) cap_flags[0] = 1'b1;
      if (cap_count == IDX_ACTION   && w.frame_byte == ACT_VENDOR) cap_flags[1] = 1'b1;
      if (cap_count == IDX_OUI0     && w.frame_byte == WFA_OUI0)   cap_flags[2] = 1'b1;
      if (cap_count == IDX_OUI1     && w.frame_byte == WFA_OUI1)   cap_flags[3] = 1'b1;
      if (cap_count == IDX_OUI2     && w.frame_byte == WFA_OUI2)   cap_flags[4] = 1'b1;
      if (cap_count == IDX_SSID_ID)  cap_ssid[15:8] = w.frame_byte;
      if (cap_count == IDX_SSID_LEN) cap_ssid[7:0]  = w.frame_byte;
      cap_count++;
    end
    if (!w.last_byte) return 1'b0;

    len = cap_count;
    if (len > FCS_LEN) len = len - FCS_LEN;
    rep.event_res   = EV_NONE;
    rep.source_addr = cap_src;

    if (w.mgmt_frame && len >= MIN_HDR_LEN) begin
      if (cap_type == TYPE_BEACON && cap_src == HOSTILE_ADDR) begin
        if (host_known) begin
          if (host_seen != 16'hFFFF) host_seen++;
          rep.event_res = EV_HOST_AGAIN;
        end else begin
          // name length is only trusted when the whole ssid element fits before the fcs
          name_sz   = int'(cap_ssid[7:0]);
          host_name = '0;
          if (len > SSID_HDR_END && cap_ssid[15:8] == 8'h00 && name_sz > 0 &&
              name_sz < NAME_LEN_LIMIT && SSID_HDR_END + name_sz < len)
            host_name = 5'(name_sz);
          host_known = 1'b1;
          host_seen  = 16'd1;
          rep.event_res = EV_HOST_NEW;
        end
        host_sig         = w.rssi;
        rep.signal       = host_sig;
        rep.seen_count   = host_seen;
        rep.name_length  = host_name;
      end else if (cap_type == TYPE_ACTION && len >= MIN_ACTION_LEN &&
                   cap_flags == ACT_ALL_HIT) begin
        used = slots_used;
        if (used < SLOTS) begin
          hit = 1'b0;
          for (int i = 0; i < SLOTS; i++) begin
            if (!hit && i < int'(used) && slot_addr[i] == cap_src) begin
              hit      = 1'b1;
              rep.slot = 2'(i);
            end
          end
          if (hit) begin
            slot_sig[rep.slot] = w.rssi;
            rep.event_res = EV_DRONE_AGAIN;
          end else begin
            rep.slot = 2'(used);
            slot_addr[used] = cap_src;
            slot_sig[used]  = w.rssi;
            slots_used = used + 1;
            rep.event_res = EV_DRONE_NEW;
          end
          rep.signal = slot_sig[rep.slot];
        end else begin
          // full table: even a known source is neither refreshed nor reported
          rep.event_res = EV_DRONE_FULL;
        end
      end
    end
    rep.drone_count = 3'(slots_used);
    clear_capture();
    return 1'b1;
  endfunction

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", field, want, got);
      mismatch_total++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_capture();
      for (int i = 0; i < SLOTS; i++) begin
        slot_addr[i] = '0;
        slot_sig[i]  = '0;
      end
      slots_used = 0;
      host_known = 1'b0;
      host_sig   = '0;
      host_seen  = '0;
      host_name  = '0;
      expected_reports.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (predict_contact(in_word, fresh_rep)) expected_reports.push_back(fresh_rep);
      end
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected report word %p", out_word);
          mismatch_total++;
        end else begin
          oldest = expected_reports.pop_front();
          check_field("event_res",   oldest.event_res,   out_word.event_res);
          check_field("slot",        oldest.slot,        out_word.slot);
          check_field("source_addr", oldest.source_addr, out_word.source_addr);
          check_field("signal",      oldest.signal,      out_word.signal);
          check_field("seen_count",  oldest.seen_count,  out_word.seen_count);
          check_field("name_length", oldest.name_length, out_word.name_length);
          check_field("drone_count", oldest.drone_count, out_word.drone_count);
          checked_total++;
          if (oldest.event_res == EV_HOST_NEW || oldest.event_res == EV_HOST_AGAIN)
            hostile_total++;
          else if (oldest.event_res != EV_NONE)
            drone_total++;
        end
      end
    end
    fail_count      <= mismatch_total;
    pending_count   <= expected_reports.size();
    reports_checked <= checked_total;
    hostile_reports <= hostile_total;
    drone_reports   <= drone_total;
  end

endmodule

// ===== dv/testbench.sv =====
// top of the contact tracker bench: clock, reset, frame stimulus, receiver stalls and verdict
module testbench;
  import mftc_pkg::*;

  localparam int RANDOM_BYTES   = 1000;
  localparam int RANDOM_FRAMES  = 24;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned reports_checked;
  int unsigned hostile_reports;
  int unsigned drone_reports;

  logic [7:0]  frame_buf [$];
  logic [47:0] drone_pool [6] = '{48'h02_11_22_33_44_55, 48'hFFFF_FFFF_FFFF, 48'h0,
                                  48'hDEAD_BEEF_DEAD, 48'h12_34_56_78_9A_BC,
                                  48'h06_A0_0F_C3_5A_E1};
  bit          tx_gaps;
  logic        rx_idle;
  logic        hold_req;
  bit          hold_done;
  int unsigned frames_sent;
  int unsigned bytes_sent;
  int unsigned quiet_cycles;
  int unsigned rand_frames;
  int unsigned rand_start;
  int unsigned pick;
  int          total;
  logic [7:0]  ssid_id;
  logic [7:0]  ssid_len;
  logic [7:0]  kind;
  bit          mgmt;

  always #5 clk = ~clk;

  mgmt_frame_contact_tracker_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  mftc_report_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_word         (in_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_word        (out_word),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .reports_checked (reports_checked),
    .hostile_reports (hostile_reports),
    .drone_reports   (drone_reports)
  );

  function automatic logic [47:0] pick_source();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    if ($urandom_range(0, 3) != 0) return drone_pool[$urandom_range(0, 5)];
    return raw[47:0];
  endfunction

  task automatic put_byte(input int idx, input logic [7:0] value);
    if (idx < frame_buf.size()) frame_buf[idx] = value;
  endtask

  // random body with type byte and source address laid in
  task automatic shape_frame(input logic [7:0] ftype, input logic [47:0] src, input int len);
    frame_buf.delete();
    for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
    put_byte(IDX_TYPE, ftype);
    for (int i = 0; i < 6; i++) put_byte(IDX_SRC_FIRST + i, src[47 - 8 * i -: 8]);
  endtask

  task automatic mark_action();
    put_byte(IDX_CATEGORY, CAT_PUBLIC);
    put_byte(IDX_ACTION, ACT_VENDOR);
    put_byte(IDX_OUI0, WFA_OUI0);
    put_byte(IDX_OUI1, WFA_OUI1);
    put_byte(IDX_OUI2, WFA_OUI2);
  endtask

  // spoil one of the five public action match bytes
  task automatic break_action();
    int idx;
    case ($urandom_range(0, 4))
      0:       idx = IDX_CATEGORY;
      1:       idx = IDX_ACTION;
      2:       idx = IDX_OUI0;
      3:       idx = IDX_OUI1;
      default: idx = IDX_OUI2;
    endcase
    if (idx < frame_buf.size()) frame_buf[idx] = frame_buf[idx] ^ 8'($urandom_range(1, 255));
  endtask

  task automatic mark_ssid(input logic [7:0] id, input logic [7:0] len);
    put_byte(IDX_SSID_ID, id);
    put_byte(IDX_SSID_LEN, len);
  endtask

  task automatic put_word(input in_word_t w);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // side fields only matter on the last byte, so they are noise elsewhere
  task automatic send_frame(input bit is_mgmt, input logic [7:0] strength,
                            input logic [31:0] stamp);
    in_word_t w;
    for (int i = 0; i < frame_buf.size(); i++) begin
      w.frame_byte = frame_buf[i];
      w.last_byte  = (i == frame_buf.size() - 1);
      if (w.last_byte) begin
        w.mgmt_frame = is_mgmt;
        w.rssi       = strength;
        w.time_ms    = stamp;
      end else begin
        w.mgmt_frame = 1'($urandom_range(0, 1));
        w.rssi       = 8'($urandom_range(0, 255));
        w.time_ms    = $urandom();
      end
      put_word(w);
    end
    frames_sent++;
  endtask

  // receiver: short random stalls, one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("mgmt_frame_contact_tracker_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_word  <= '0;
    rx_idle  <= 1'b1;
    hold_req <= 1'b0;
    tx_gaps  = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // tiny frames: no fcs drop at four bytes or fewer, address cut short
    shape_frame(TYPE_BEACON, HOSTILE_ADDR, 3);
    send_frame(1'b1, 8'h80, 32'h0);
    shape_frame(8'h00, 48'h0, 4);
    send_frame(1'b1, 8'h7F, 32'hFFFF_FFFF);
    shape_frame(TYPE_ACTION, 48'h0, 5);
    send_frame(1'b1, 8'($urandom_range(0, 255)), $urandom());
    shape_frame(TYPE_BEACON, HOSTILE_ADDR, 13);
    send_frame(1'b1, 8'($urandom_range(0, 255)), $urandom());
    // one byte short of a header, then a full beacon that is not management
    shape_frame(TYPE_BEACON, HOSTILE_ADDR, 27);
    send_frame(1'b1, 8'($urandom_range(0, 255)), $urandom());
    shape_frame(TYPE_BEACON, HOSTILE_ADDR, 28);
    send_frame(1'b0, 8'($urandom_range(0, 255)), $urandom());

    // first sighting fixes the name length for good, so pick one layout
    case ($urandom_range(0, 4))
      0:       begin ssid_id = 8'h00; ssid_len = 8'd5;  total = 48; end
      1:       begin ssid_id = 8'h00; ssid_len = 8'd6;  total = 48; end // runs into fcs
      2:       begin ssid_id = 8'h01; ssid_len = 8'd5;  total = 48; end // not an ssid
      3:       begin ssid_id = 8'h00; ssid_len = 8'd0;  total = 48; end // hidden
      default: begin ssid_id = 8'h00; ssid_len = 8'd31; total = 74; end
    endcase
    shape_frame(TYPE_BEACON, HOSTILE_ADDR, total);
    mark_ssid(ssid_id, ssid_len);
    send_frame(1'b1, 8'h80, 32'h0);
    shape_frame(TYPE_BEACON, HOSTILE_ADDR, 28);
    send_frame(1'b1, 8'h7F, 32'hFFFF_FFFF);
    shape_frame(TYPE_BEACON, 48'hDEAD_BEEF_DEAC, 40);
    send_frame(1'b1, 8'($urandom_range(0, 255)), $urandom());

    // drone table: insert, short action ignored, refresh, broken body, fill, full
    shape_frame(TYPE_ACTION, drone_pool[0], 36);
    mark_action();
    send_frame(1'b1, 8'h80, $urandom());
    shape_frame(TYPE_ACTION, drone_pool[0], 35);
    mark_action();
    send_frame(1'b1, 8'($urandom_range(0, 255)), $urandom());
    shape_frame(TYPE_ACTION, drone_pool[0], 40);
    mark_action();
    send_frame(1'b1, 8'h7F, $urandom());
    shape_frame(TYPE_ACTION, drone_pool[1], 44);
    mark_action();
    send_frame(1'b1, 8'($urandom_range(0, 255)), $urandom());
    shape_frame(TYPE_ACTION, drone_pool[2], 44);
    mark_action();
    break_action();
    send_frame(1'b1, 8'($urandom_range(0, 255)), $urandom());
    shape_frame(TYPE_ACTION, drone_pool[1], 50);
    mark_action();
    send_frame(1'b1, 8'($urandom_range(0, 255)), $urandom());
    shape_frame(TYPE_ACTION, drone_pool[2], 36);
    mark_action();
    send_frame(1'b1, 8'($urandom_range(0, 255)), $urandom());
    shape_frame(TYPE_ACTION, drone_pool[3], 36);
    mark_action();
    send_frame(1'b1, 8'($urandom_range(0, 255)), $urandom());
    shape_frame(TYPE_ACTION, drone_pool[4], 36);
    mark_action();
    send_frame(1'b1, 8'($urandom_range(0, 255)), $urandom());
    shape_frame(TYPE_ACTION, drone_pool[0], 36);
    mark_action();
    send_frame(1'b1, 8'($urandom_range(0, 255)), $urandom());

    rand_start  = bytes_sent;
    rand_frames = 0;
    while (bytes_sent - rand_start < RANDOM_BYTES || rand_frames < RANDOM_FRAMES) begin
      if (bytes_sent - rand_start >= RANDOM_BYTES * 3 / 4) begin
        tx_gaps = 1'b0;
        rx_idle <= 1'b0;
      end else begin
        tx_gaps = ($urandom_range(0, 2) != 0);
      end
      // sender keeps going while the receiver holds off, until in_stall holds a final byte
      if (rand_frames == 12) hold_req <= 1'b1;
      mgmt = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        shape_frame(TYPE_ACTION, pick_source(), $urandom_range(36, 60));
        mark_action();
      end else if (pick < 55) begin
        shape_frame(TYPE_BEACON, HOSTILE_ADDR, $urandom_range(28, 80));
        mark_ssid(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h00,
                  8'($urandom_range(0, 40)));
      end else if (pick < 65) begin
        total = $urandom_range(28, 60);
        shape_frame(TYPE_ACTION, pick_source(), total);
        mark_action();
        if (total >= 36) break_action();
      end else if (pick < 75) begin
        case ($urandom_range(0, 2))
          0:       kind = TYPE_BEACON;
          1:       kind = TYPE_ACTION;
          default: kind = 8'($urandom_range(0, 255));
        endcase
        shape_frame(kind, ($urandom_range(0, 1) != 0) ? HOSTILE_ADDR : pick_source(),
                    $urandom_range(1, 30));
      end else if (pick < 85) begin
        mgmt = 1'b0;
        if ($urandom_range(0, 1) != 0) begin
          shape_frame(TYPE_BEACON, HOSTILE_ADDR, $urandom_range(28, 60));
        end else begin
          shape_frame(TYPE_ACTION, pick_source(), $urandom_range(36, 60));
          mark_action();
        end
      end else begin
        mgmt = 1'($urandom_range(0, 1));
        shape_frame(8'($urandom_range(0, 255)), pick_source(), $urandom_range(1, 64));
      end
      send_frame(mgmt, 8'($urandom_range(0, 255)), $urandom());
      rand_frames++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d frames in %0d bytes, short, non-management and broken",
             frames_sent, bytes_sent);
    $display("%0d reports checked: %0d hostile, %0d drone table", reports_checked,
             hostile_reports, drone_reports);
    if (fail_count == 0) begin
      $display("mgmt_frame_contact_tracker_core regression: pass");
    end else begin
      $display("mgmt_frame_contact_tracker_core regression: fail");
    end
    $finish;
  end

endmodule
